### src/ucee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucee_pkg;

    // event codes on the input channel
    typedef enum logic [1:0] {
        CMD_BUS_RESET = 2'd0,
        CMD_SETUP     = 2'd1,
        CMD_IN_DONE   = 2'd2,
        CMD_OTHER     = 2'd3
    } cmd_t;

    // standard request and descriptor codes
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;

    // largest legal control packet
    localparam logic [6:0] PACKET_LIMIT = 7'd64;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MAX_PACKET      = 3'd0,
        REG_DEVICE_DESC_LEN = 3'd1,
        REG_CONFIG_HEAD_LEN = 3'd2,
        REG_CONFIG_FULL_LEN = 3'd3,
        REG_LANG_STRING_LEN = 3'd4,
        REG_TEXT_STRING_LEN = 3'd5
    } reg_idx_t;

    // reset values of the configuration registers
    localparam logic [6:0] RST_MAX_PACKET      = 7'd64;
    localparam logic [7:0] RST_DEVICE_DESC_LEN = 8'd18;
    localparam logic [7:0] RST_CONFIG_HEAD_LEN = 8'd9;
    localparam logic [9:0] RST_CONFIG_FULL_LEN = 10'd32;
    localparam logic [7:0] RST_LANG_STRING_LEN = 8'd4;
    localparam logic [7:0] RST_TEXT_STRING_LEN = 8'd16;

    // enumeration phase
    typedef enum logic [1:0] {
        PH_DEFAULT = 2'd0,
        PH_ADDRESS = 2'd1,
        PH_CONFIG  = 2'd2,
        PH_READY   = 2'd3
    } phase_t;

    // transmit data source
    typedef enum logic [2:0] {
        SRC_RX_BUF      = 3'd0,
        SRC_DEVICE      = 3'd1,
        SRC_CONFIG_HEAD = 3'd2,
        SRC_CONFIG_FULL = 3'd3,
        SRC_LANG        = 3'd4,
        SRC_TEXT        = 3'd5
    } src_t;

    // classified operation handed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_BUS_RESET,
        OP_IN_DONE,
        OP_GET_DEVICE,
        OP_GET_CONFIG,
        OP_GET_LANG,
        OP_GET_TEXT,
        OP_SET_ADDRESS,
        OP_SET_CONFIG,
        OP_ZERO_LEN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] addr;
    } op_entry_t;

endpackage

`default_nettype wire

### src/ucee_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ucee_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  request;
    logic [15:0] value;
    logic [15:0] index;

    modport source (output valid, output cmd, output request, output value,
                    output index, input ready);
    modport sink   (input valid, input cmd, input request, input value,
                    input index, output ready);
endinterface

`default_nettype wire

### src/ucee_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ucee_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_armed;
    logic       tx_toggle;
    logic [6:0] tx_len;
    logic [2:0] tx_source;
    logic [9:0] tx_offset;
    logic [6:0] device_address;
    logic [1:0] enum_state;

    modport source (output valid, output tx_armed, output tx_toggle, output tx_len,
                    output tx_source, output tx_offset, output device_address,
                    output enum_state, input ready);
    modport sink   (input valid, input tx_armed, input tx_toggle, input tx_len,
                    input tx_source, input tx_offset, input device_address,
                    input enum_state, output ready);
endinterface

`default_nettype wire

### src/ucee_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ucee_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/usb_control_endpoint_engine_unit.sv
// channel  role    width  contents
// evt      sink    42     cmd, request, value, index
// rsp      source  31     tx_armed, tx_toggle, tx_len, tx_source, tx_offset,
//                         device_address, enum_state
// cfg      sink    13     register index, write data (always ready)
//
// one event per cycle sustained while the result channel is ready; a result appears in the cycle
// after the event is taken from the queue, since the back end's state registers are the result
// rst_n clears the engine state, the queue, and loads the default register values
// a stalled result holds the back end; the queue keeps taking events until full
`timescale 1ns / 1ps
`default_nettype none

module usb_control_endpoint_engine_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    ucee_evt_if.sink   evt,
    ucee_rsp_if.source rsp,
    ucee_cfg_if.sink   cfg
);

    logic                push_valid, push_ready;
    logic                pop_valid, pop_ready;
    ucee_pkg::op_entry_t push_entry, pop_entry;

    // classify incoming events
    ucee_front u_front (
        .evt        (evt),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decoupling queue
    ucee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // endpoint state and results
    ucee_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### src/ucee_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ucee_front (
    ucee_evt_if.sink              evt,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ucee_pkg::op_entry_t   push_entry
);

    // handshake passes straight through to the queue
    assign push_valid = evt.valid;
    assign evt.ready  = push_ready;

    // classify the event into one operation
    always_comb
    begin
        push_entry.addr = evt.value[6:0];
        push_entry.op   = ucee_pkg::OP_NOP;
        unique case (ucee_pkg::cmd_t'(evt.cmd))
            ucee_pkg::CMD_BUS_RESET: push_entry.op = ucee_pkg::OP_BUS_RESET;
            ucee_pkg::CMD_IN_DONE:   push_entry.op = ucee_pkg::OP_IN_DONE;
            ucee_pkg::CMD_OTHER:     push_entry.op = ucee_pkg::OP_NOP;
            ucee_pkg::CMD_SETUP:
            begin
                priority if (evt.request == ucee_pkg::REQ_GET_DESCRIPTOR)
                begin
                    priority if (evt.value[15:8] == ucee_pkg::DESC_DEVICE)
                        push_entry.op = ucee_pkg::OP_GET_DEVICE;
                    else if (evt.value[15:8] == ucee_pkg::DESC_CONFIG)
                        push_entry.op = ucee_pkg::OP_GET_CONFIG;
                    else if (evt.value[15:8] == ucee_pkg::DESC_STRING)
                        push_entry.op = (evt.index == 16'd0) ? ucee_pkg::OP_GET_LANG
                                                             : ucee_pkg::OP_GET_TEXT;
                    else
                        push_entry.op = ucee_pkg::OP_ZERO_LEN;
                end
                else if (evt.request == ucee_pkg::REQ_SET_ADDRESS)
                    push_entry.op = ucee_pkg::OP_SET_ADDRESS;
                else if (evt.request == ucee_pkg::REQ_SET_CONFIGURATION)
                    push_entry.op = ucee_pkg::OP_SET_CONFIG;
                else
                    push_entry.op = ucee_pkg::OP_ZERO_LEN;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/ucee_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ucee_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  ucee_pkg::op_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output ucee_pkg::op_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ucee_pkg::op_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

### src/ucee_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ucee_back (
    input  logic                clk,
    input  logic                rst_n,
    ucee_cfg_if.sink            cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  ucee_pkg::op_entry_t pop_entry,
    ucee_rsp_if.source          rsp
);

    // configuration registers
    logic [6:0] max_packet_reg;
    logic [7:0] device_desc_len_reg;
    logic [7:0] config_head_len_reg;
    logic [9:0] config_full_len_reg;
    logic [7:0] lang_string_len_reg;
    logic [7:0] text_string_len_reg;

    // engine state, which is also the result register
    ucee_pkg::phase_t phase_reg, phase_next;
    ucee_pkg::src_t   src_reg, src_next;
    logic [6:0] pending_addr_reg, pending_addr_next;
    logic [6:0] applied_addr_reg, applied_addr_next;
    logic [9:0] bytes_left_reg, bytes_left_next;
    logic [6:0] packet_reg, packet_next;
    logic [9:0] offset_reg, offset_next;
    logic       toggle_reg, toggle_next;
    logic       armed_reg, armed_next;
    logic       rsp_valid_reg, rsp_valid_next;

    logic             step;
    logic [6:0]       mp_eff;
    logic             do_arm;
    ucee_pkg::src_t   arm_src;
    logic [9:0]       arm_size;
    logic [9:0]       bl_after;

    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_reg      <= ucee_pkg::RST_MAX_PACKET;
            device_desc_len_reg <= ucee_pkg::RST_DEVICE_DESC_LEN;
            config_head_len_reg <= ucee_pkg::RST_CONFIG_HEAD_LEN;
            config_full_len_reg <= ucee_pkg::RST_CONFIG_FULL_LEN;
            lang_string_len_reg <= ucee_pkg::RST_LANG_STRING_LEN;
            text_string_len_reg <= ucee_pkg::RST_TEXT_STRING_LEN;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ucee_pkg::REG_MAX_PACKET:      max_packet_reg      <= cfg.data[6:0];
                ucee_pkg::REG_DEVICE_DESC_LEN: device_desc_len_reg <= cfg.data[7:0];
                ucee_pkg::REG_CONFIG_HEAD_LEN: config_head_len_reg <= cfg.data[7:0];
                ucee_pkg::REG_CONFIG_FULL_LEN: config_full_len_reg <= cfg.data;
                ucee_pkg::REG_LANG_STRING_LEN: lang_string_len_reg <= cfg.data[7:0];
                ucee_pkg::REG_TEXT_STRING_LEN: text_string_len_reg <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // take the next operation when the result slot is free or being drained
    assign step      = pop_valid && (!rsp_valid_reg || rsp.ready);
    assign pop_ready = !rsp_valid_reg || rsp.ready;

    // packet size clamped to the legal range
    always_comb
    begin
        priority if (max_packet_reg == 7'd0)
            mp_eff = 7'd1;
        else if (max_packet_reg > ucee_pkg::PACKET_LIMIT)
            mp_eff = ucee_pkg::PACKET_LIMIT;
        else
            mp_eff = max_packet_reg;
    end

    assign bl_after = (bytes_left_reg > {3'b000, packet_reg})
                    ? bytes_left_reg - {3'b000, packet_reg} : 10'd0;

    // next state for one operation
    always_comb
    begin
        phase_next        = phase_reg;
        src_next          = src_reg;
        pending_addr_next = pending_addr_reg;
        applied_addr_next = applied_addr_reg;
        bytes_left_next   = bytes_left_reg;
        packet_next       = packet_reg;
        offset_next       = offset_reg;
        toggle_next       = toggle_reg;
        armed_next        = armed_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        do_arm            = 1'b0;
        arm_src           = ucee_pkg::SRC_RX_BUF;
        arm_size          = 10'd0;

        if (step)
        begin
            rsp_valid_next = 1'b1;
            unique case (pop_entry.op)
                ucee_pkg::OP_NOP: ;
                ucee_pkg::OP_BUS_RESET:
                begin
                    pending_addr_next = 7'd0;
                    applied_addr_next = 7'd0;
                end
                ucee_pkg::OP_IN_DONE:
                begin
                    bytes_left_next = bl_after;
                    if (bl_after == 10'd0)
                    begin
                        armed_next  = 1'b0;
                        toggle_next = 1'b0;
                        packet_next = 7'd0;
                        src_next    = ucee_pkg::SRC_RX_BUF;
                        offset_next = 10'd0;
                    end
                    else
                    begin
                        offset_next = offset_reg + {3'b000, packet_reg};
                        if ({3'b000, packet_reg} > bl_after)
                            packet_next = bl_after[6:0];
                        toggle_next = !toggle_reg;
                        armed_next  = 1'b1;
                    end
                    if (phase_reg == ucee_pkg::PH_ADDRESS)
                        applied_addr_next = pending_addr_reg;
                end
                ucee_pkg::OP_GET_DEVICE:
                begin
                    do_arm   = 1'b1;
                    arm_src  = ucee_pkg::SRC_DEVICE;
                    arm_size = {2'b00, device_desc_len_reg};
                end
                ucee_pkg::OP_GET_CONFIG:
                begin
                    do_arm = 1'b1;
                    if (phase_reg == ucee_pkg::PH_CONFIG)
                    begin
                        arm_src  = ucee_pkg::SRC_CONFIG_FULL;
                        arm_size = config_full_len_reg;
                    end
                    else
                    begin
                        arm_src    = ucee_pkg::SRC_CONFIG_HEAD;
                        arm_size   = {2'b00, config_head_len_reg};
                        phase_next = ucee_pkg::PH_CONFIG;
                    end
                end
                ucee_pkg::OP_GET_LANG:
                begin
                    do_arm   = 1'b1;
                    arm_src  = ucee_pkg::SRC_LANG;
                    arm_size = {2'b00, lang_string_len_reg};
                end
                ucee_pkg::OP_GET_TEXT:
                begin
                    do_arm   = 1'b1;
                    arm_src  = ucee_pkg::SRC_TEXT;
                    arm_size = {2'b00, text_string_len_reg};
                end
                ucee_pkg::OP_SET_ADDRESS:
                begin
                    do_arm            = 1'b1;
                    phase_next        = ucee_pkg::PH_ADDRESS;
                    pending_addr_next = pop_entry.addr;
                end
                ucee_pkg::OP_SET_CONFIG:
                begin
                    do_arm     = 1'b1;
                    phase_next = ucee_pkg::PH_READY;
                end
                ucee_pkg::OP_ZERO_LEN:
                begin
                    do_arm = 1'b1;
                end
                default: ;
            endcase

            // arm the first packet of a reply, zero length keeps source and offset
            if (do_arm)
            begin
                packet_next     = (arm_size < {3'b000, mp_eff}) ? arm_size[6:0] : mp_eff;
                bytes_left_next = arm_size;
                if (arm_size != 10'd0)
                begin
                    src_next    = arm_src;
                    offset_next = 10'd0;
                end
                toggle_next = !toggle_reg;
                armed_next  = 1'b1;
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ucee_pkg::PH_DEFAULT;
            src_reg          <= ucee_pkg::SRC_RX_BUF;
            pending_addr_reg <= 7'd0;
            applied_addr_reg <= 7'd0;
            bytes_left_reg   <= 10'd0;
            packet_reg       <= 7'd0;
            offset_reg       <= 10'd0;
            toggle_reg       <= 1'b0;
            armed_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            src_reg          <= src_next;
            pending_addr_reg <= pending_addr_next;
            applied_addr_reg <= applied_addr_next;
            bytes_left_reg   <= bytes_left_next;
            packet_reg       <= packet_next;
            offset_reg       <= offset_next;
            toggle_reg       <= toggle_next;
            armed_reg        <= armed_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // result channel
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.tx_armed       = armed_reg;
    assign rsp.tx_toggle      = toggle_reg;
    assign rsp.tx_len         = packet_reg;
    assign rsp.tx_source      = src_reg;
    assign rsp.tx_offset      = offset_reg;
    assign rsp.device_address = applied_addr_reg;
    assign rsp.enum_state     = phase_reg;

endmodule

`default_nettype wire

### dv/tb_usb_control_endpoint_engine_unit.sv
`timescale 1ns / 1ps

module tb_usb_control_endpoint_engine_unit;
    import ucee_pkg::*;

    // one event as seen on the input channel
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  request;
        logic [15:0] value;
        logic [15:0] index;
    } evt_item_t;

    // endpoint status reported for each event
    typedef struct packed {
        logic       armed;
        logic       toggle;
        logic [6:0] len;
        src_t       source;
        logic [9:0] offset;
        logic [6:0] address;
        phase_t     phase;
    } ep0_status_t;

    // tracks the ep0 engine and checks every reported status in order
    class ep0_status_tracker;
        // register copies
        logic [6:0]  max_packet;
        logic [7:0]  device_len;
        logic [7:0]  head_len;
        logic [9:0]  full_len;
        logic [7:0]  lang_len;
        logic [7:0]  text_len;
        // engine state
        phase_t      phase;
        logic [6:0]  pending_addr;
        logic [6:0]  applied_addr;
        logic [9:0]  bytes_left;
        logic [6:0]  pkt_bytes;
        src_t        source;
        logic [9:0]  offset;
        logic        toggle;
        logic        armed;
        ep0_status_t status_due_q[$];
        int unsigned mismatches;
        int unsigned statuses_seen;

        function new();
            max_packet   = RST_MAX_PACKET;
            device_len   = RST_DEVICE_DESC_LEN;
            head_len     = RST_CONFIG_HEAD_LEN;
            full_len     = RST_CONFIG_FULL_LEN;
            lang_len     = RST_LANG_STRING_LEN;
            text_len     = RST_TEXT_STRING_LEN;
            phase        = PH_DEFAULT;
            pending_addr = '0;
            applied_addr = '0;
            bytes_left   = '0;
            pkt_bytes    = '0;
            source       = SRC_RX_BUF;
            offset       = '0;
            toggle       = 1'b0;
            armed        = 1'b0;
            mismatches   = 0;
            statuses_seen = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [9:0] wdata);
            case (idx)
                REG_MAX_PACKET:      max_packet = wdata[6:0];
                REG_DEVICE_DESC_LEN: device_len = wdata[7:0];
                REG_CONFIG_HEAD_LEN: head_len   = wdata[7:0];
                REG_CONFIG_FULL_LEN: full_len   = wdata;
                REG_LANG_STRING_LEN: lang_len   = wdata[7:0];
                REG_TEXT_STRING_LEN: text_len   = wdata[7:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything above the limit acts as the limit
        function logic [6:0] packet_cap();
            if (max_packet == '0)
                return 7'd1;
            if (max_packet > PACKET_LIMIT)
                return PACKET_LIMIT;
            return max_packet;
        endfunction

        // first packet of a control reply; zero length keeps source and offset
        function void arm_reply(src_t src, logic [9:0] size);
            logic [6:0] cap;
            cap = packet_cap();
            pkt_bytes  = (size < {3'b000, cap}) ? size[6:0] : cap;
            bytes_left = size;
            if (size != '0)
            begin
                source = src;
                offset = '0;
            end
            toggle = ~toggle;
            armed  = 1'b1;
        endfunction

        // one IN transaction went out
        function void in_done();
            if (bytes_left > {3'b000, pkt_bytes})
                bytes_left = bytes_left - {3'b000, pkt_bytes};
            else
                bytes_left = '0;
            if (bytes_left == '0)
            begin
                armed     = 1'b0;
                toggle    = 1'b0;
                pkt_bytes = '0;
                source    = SRC_RX_BUF;
                offset    = '0;
            end
            else
            begin
                offset = offset + {3'b000, pkt_bytes};
                if ({3'b000, pkt_bytes} > bytes_left)
                    pkt_bytes = bytes_left[6:0];
                toggle = ~toggle;
                armed  = 1'b1;
            end
            if (phase == PH_ADDRESS)
                applied_addr = pending_addr;
        endfunction

        function void setup(evt_item_t e);
            src_t       src;
            logic [9:0] size;
            src  = SRC_RX_BUF;
            size = '0;
            if (e.request == REQ_GET_DESCRIPTOR)
            begin
                case (e.value[15:8])
                    DESC_DEVICE:
                    begin
                        src  = SRC_DEVICE;
                        size = {2'b00, device_len};
                    end
                    DESC_CONFIG:
                    begin
                        if (phase == PH_CONFIG)
                        begin
                            src  = SRC_CONFIG_FULL;
                            size = full_len;
                        end
                        else
                        begin
                            src   = SRC_CONFIG_HEAD;
                            size  = {2'b00, head_len};
                            phase = PH_CONFIG;
                        end
                    end
                    DESC_STRING:
                    begin
                        if (e.index == '0)
                        begin
                            src  = SRC_LANG;
                            size = {2'b00, lang_len};
                        end
                        else
                        begin
                            src  = SRC_TEXT;
                            size = {2'b00, text_len};
                        end
                    end
                    default: ;
                endcase
            end
            else if (e.request == REQ_SET_ADDRESS)
            begin
                phase        = PH_ADDRESS;
                pending_addr = e.value[6:0];
            end
            else if (e.request == REQ_SET_CONFIGURATION)
            begin
                phase = PH_READY;
            end
            arm_reply(src, size);
        endfunction

        // accepted event: advance the engine and queue the status it reports
        function void take_event(evt_item_t e);
            case (e.cmd)
                CMD_BUS_RESET:
                begin
                    applied_addr = '0;
                    pending_addr = '0;
                end
                CMD_SETUP:   setup(e);
                CMD_IN_DONE: in_done();
                default: ;
            endcase
            status_due_q.push_back('{armed, toggle, pkt_bytes, source, offset,
                                     applied_addr, phase});
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] status %0d: %s", $time, statuses_seen, msg);
        endtask

        task check_status(ep0_status_t got);
            ep0_status_t want;
            statuses_seen++;
            if (status_due_q.size() == 0)
            begin
                report_mismatch("status reported with no event outstanding");
                return;
            end
            want = status_due_q.pop_front();
            if (got.armed !== want.armed)
                report_mismatch($sformatf("tx_armed got %0d expected %0d",
                                          got.armed, want.armed));
            if (got.toggle !== want.toggle)
                report_mismatch($sformatf("tx_toggle got %0d expected %0d",
                                          got.toggle, want.toggle));
            if (got.len !== want.len)
                report_mismatch($sformatf("tx_len got %0d expected %0d",
                                          got.len, want.len));
            if (got.source !== want.source)
                report_mismatch($sformatf("tx_source got %0d expected %0d",
                                          got.source, want.source));
            if (got.offset !== want.offset)
                report_mismatch($sformatf("tx_offset got %0d expected %0d",
                                          got.offset, want.offset));
            if (got.address !== want.address)
                report_mismatch($sformatf("device_address got %0d expected %0d",
                                          got.address, want.address));
            if (got.phase !== want.phase)
                report_mismatch($sformatf("enum_state got %0d expected %0d",
                                          got.phase, want.phase));
        endtask

        function int unsigned outstanding();
            return status_due_q.size();
        endfunction
    endclass

    localparam int unsigned HOLD_OFF_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ucee_evt_if evt_ch();
    ucee_rsp_if rsp_ch();
    ucee_cfg_if cfg_ch();

    ep0_status_tracker tracker;

    // stimulus-side copies of the settings, used only to size IN bursts
    int unsigned pkt_cap_now = 64;
    int unsigned len_device = RST_DEVICE_DESC_LEN;
    int unsigned len_head = RST_CONFIG_HEAD_LEN;
    int unsigned len_full = RST_CONFIG_FULL_LEN;
    int unsigned len_lang = RST_LANG_STRING_LEN;
    int unsigned len_text = RST_TEXT_STRING_LEN;

    int unsigned events_sent = 0;
    bit sender_gaps_off = 1'b0;
    bit receiver_stalls_off = 1'b0;
    bit hold_off_req = 1'b0;

    usb_control_endpoint_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watch all three channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.write_reg(reg_idx_t'(cfg_ch.index), cfg_ch.data);
            if (evt_ch.valid && evt_ch.ready)
                tracker.take_event(evt_item_t'{cmd_t'(evt_ch.cmd), evt_ch.request,
                                               evt_ch.value, evt_ch.index});
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_status(ep0_status_t'{rsp_ch.tx_armed, rsp_ch.tx_toggle,
                                                   rsp_ch.tx_len,
                                                   src_t'(rsp_ch.tx_source),
                                                   rsp_ch.tx_offset,
                                                   rsp_ch.device_address,
                                                   phase_t'(rsp_ch.enum_state)});
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(bit off);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (off || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result receiver with random stalls and a long hold-off on request
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_count;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                rsp_ch.ready <= 1'b0;
                hold_count = HOLD_OFF_CYCLES;
                while (hold_count > 0)
                begin
                    @(posedge clk);
                    hold_count--;
                end
                hold_off_req = 1'b0;
            end
            else if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(receiver_stalls_off);
            end
        end
    end

    // offer one event and wait for its transaction
    task automatic send_event(cmd_t cmd, logic [7:0] req, logic [15:0] val,
                              logic [15:0] idx);
        int unsigned gap;
        gap = pick_gap(sender_gaps_off);
        if (gap != 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid   <= 1'b1;
        evt_ch.cmd     <= cmd;
        evt_ch.request <= req;
        evt_ch.value   <= val;
        evt_ch.index   <= idx;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        if (cmd != CMD_OTHER)
            events_sent++;
    endtask

    // stop offering and wait until every status has come back
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // write all six registers back to back; spare upper bits carry junk
    task automatic program_regs(logic [6:0] mp, logic [7:0] dev_len,
                                logic [7:0] hd_len, logic [9:0] fl_len,
                                logic [7:0] lg_len, logic [7:0] tx_len);
        reg_idx_t   order [6];
        logic [9:0] word [6];
        order[0] = REG_MAX_PACKET;
        order[1] = REG_DEVICE_DESC_LEN;
        order[2] = REG_CONFIG_HEAD_LEN;
        order[3] = REG_CONFIG_FULL_LEN;
        order[4] = REG_LANG_STRING_LEN;
        order[5] = REG_TEXT_STRING_LEN;
        word[0] = {3'($urandom), mp};
        word[1] = {2'($urandom), dev_len};
        word[2] = {2'($urandom), hd_len};
        word[3] = fl_len;
        word[4] = {2'($urandom), lg_len};
        word[5] = {2'($urandom), tx_len};
        for (int i = 0; i < 6; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[i];
            cfg_ch.data  <= word[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        pkt_cap_now = (mp == 0) ? 1 : ((mp > PACKET_LIMIT) ? PACKET_LIMIT : mp);
        len_device  = dev_len;
        len_head    = hd_len;
        len_full    = fl_len;
        len_lang    = lg_len;
        len_text    = tx_len;
    endtask

    // IN completions for a transfer of len bytes, sometimes one short or one extra; over 16 becomes 2 to 16
    task automatic complete_ins(int unsigned len);
        int unsigned n;
        n = (len + pkt_cap_now - 1) / pkt_cap_now;
        if (n == 0)
            n = 1;
        if (n > 16)
            n = $urandom_range(2, 16);
        if (n > 1 && $urandom_range(0, 7) == 0)
            n--;
        if ($urandom_range(0, 4) == 0)
            n++;
        repeat (n)
            send_event(CMD_IN_DONE, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic fetch_descriptor(logic [7:0] dtype, logic [15:0] idx,
                                    int unsigned len);
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, {dtype, 8'($urandom)}, idx);
        complete_ins(len);
    endtask

    function automatic bit cut_short();
        return $urandom_range(0, 9) == 0;
    endfunction

    // host enumeration with random content, sometimes cut short
    task automatic enum_sequence();
        logic [6:0] addr;
        addr = 7'($urandom);
        if ($urandom_range(0, 3) != 0)
            send_event(CMD_BUS_RESET, 8'($urandom), 16'($urandom), 16'($urandom));
        fetch_descriptor(DESC_DEVICE, 16'($urandom), len_device);
        if (cut_short())
            return;
        send_event(CMD_SETUP, REQ_SET_ADDRESS, {9'($urandom), addr}, 16'($urandom));
        complete_ins(0);
        if (cut_short())
            return;
        fetch_descriptor(DESC_CONFIG, 16'($urandom), len_head);
        fetch_descriptor(DESC_CONFIG, 16'($urandom), len_full);
        if (cut_short())
            return;
        fetch_descriptor(DESC_STRING, 16'h0000, len_lang);
        fetch_descriptor(DESC_STRING, 16'($urandom_range(1, 65535)), len_text);
        if (cut_short())
            return;
        send_event(CMD_SETUP, REQ_SET_CONFIGURATION, 16'($urandom), 16'($urandom));
        complete_ins(0);
    endtask

    // one setup of any kind followed by up to three INs
    task automatic random_setup();
        logic [7:0]  req;
        logic [7:0]  dtype;
        logic [15:0] idx;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            req = REQ_GET_DESCRIPTOR;
        else if (r < 60)
            req = REQ_SET_ADDRESS;
        else if (r < 75)
            req = REQ_SET_CONFIGURATION;
        else
            req = 8'($urandom);
        dtype = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        idx   = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
        send_event(CMD_SETUP, req, {dtype, 8'($urandom)}, idx);
        repeat ($urandom_range(0, 3))
            send_event(CMD_IN_DONE, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic noise_event();
        send_event(cmd_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                   16'($urandom));
    endtask

    task automatic run_random(int unsigned n);
        int unsigned target;
        int unsigned r;
        target = events_sent + n;
        while (events_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                enum_sequence();
            else if (r < 85)
                random_setup();
            else
                noise_event();
        end
    endtask

    task automatic random_setting();
        logic [6:0] mp;
        logic [9:0] fl;
        mp = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
        fl = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 160));
        program_regs(mp, 8'($urandom_range(0, 60)), 8'($urandom),
                     fl, 8'($urandom_range(0, 40)), 8'($urandom));
    endtask

    // directed pass at reset settings: every request kind and the corner cases
    task automatic directed_checks();
        send_event(CMD_OTHER, 8'hff, 16'hffff, 16'hffff);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0000);
        send_event(CMD_IN_DONE, 8'hff, 16'hffff, 16'hffff);
        send_event(CMD_SETUP, REQ_SET_ADDRESS, 16'hffff, 16'hffff);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_BUS_RESET, 8'hff, 16'hffff, 16'hffff);
        send_event(CMD_SETUP, REQ_SET_ADDRESS, 16'h0005, 16'h0000);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'h0000);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'hff}, 16'h0000);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h00}, 16'h0000);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h01}, 16'hffff);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        // unknown descriptor type and unknown requests give zero-length replies
        send_event(CMD_SETUP, REQ_GET_DESCRIPTOR, 16'hff00, 16'h0000);
        send_event(CMD_SETUP, 8'hff, 16'hffff, 16'hffff);
        send_event(CMD_SETUP, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, REQ_SET_CONFIGURATION, 16'h0001, 16'h0000);
        send_event(CMD_IN_DONE, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_OTHER, 8'h00, 16'h0000, 16'h0000);
    endtask

    // main sequence
    initial
    begin
        tracker = new();
        evt_ch.valid   = 1'b0;
        evt_ch.cmd     = CMD_OTHER;
        evt_ch.request = '0;
        evt_ch.value   = '0;
        evt_ch.index   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_MAX_PACKET;
        cfg_ch.data    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        drain();

        // typical small setting
        program_regs(7'd8, 8'd18, 8'd9, 10'd32, 8'd4, 8'd16);
        run_random(200);
        drain();

        // extremes, packet size zero
        program_regs(7'd0, 8'd255, 8'd0, 10'd1023, 8'd0, 8'd255);
        run_random(120);
        drain();

        // extremes, packet size above the limit
        program_regs(7'd127, 8'd0, 8'd255, 10'd0, 8'd255, 8'd0);
        run_random(120);
        drain();

        program_regs(7'd1, 8'd3, 8'd2, 10'd5, 8'd1, 8'd7);
        run_random(120);
        drain();

        program_regs(PACKET_LIMIT, 8'd255, 8'd255, 10'd1023, 8'd255, 8'd255);
        run_random(150);
        drain();

        repeat (4)
        begin
            random_setting();
            run_random(120);
            drain();
        end

        // receiver holds off while the sender keeps offering
        sender_gaps_off = 1'b1;
        hold_off_req    = 1'b1;
        run_random(50);
        sender_gaps_off = 1'b0;
        drain();

        // back to back on both sides
        random_setting();
        sender_gaps_off     = 1'b1;
        receiver_stalls_off = 1'b1;
        run_random(80);
        sender_gaps_off     = 1'b0;
        receiver_stalls_off = 1'b0;
        drain();

        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS usb_control_endpoint_engine_unit");
        else
            $display("FAIL usb_control_endpoint_engine_unit");
        $finish;
    end

    // watchdog
    initial
    begin
        #6000000;
        $display("FAIL usb_control_endpoint_engine_unit");
        $finish;
    end

endmodule

### usb_control_endpoint_engine_unit.f
src/ucee_pkg.sv
src/ucee_evt_if.sv
src/ucee_rsp_if.sv
src/ucee_cfg_if.sv
src/ucee_front.sv
src/ucee_queue.sv
src/ucee_back.sv
src/usb_control_endpoint_engine_unit.sv
dv/tb_usb_control_endpoint_engine_unit.sv
